// ===== design/ihex_pkg.sv =====
// shared types, codes and the hex digit decoder of the record parser
package ihex_pkg;

  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 32;
  localparam logic [7:0]  ColonChar = 8'h3a;

  typedef enum logic [3:0] {
    PH_COLON   = 4'd0,
    PH_LEN_HI  = 4'd1,
    PH_LEN_LO  = 4'd2,
    PH_ADDR0   = 4'd3,
    PH_ADDR1   = 4'd4,
    PH_ADDR2   = 4'd5,
    PH_ADDR3   = 4'd6,
    PH_TYPE_HI = 4'd7,
    PH_TYPE_LO = 4'd8,
    PH_DATA_HI = 4'd9,
    PH_DATA_LO = 4'd10,
    PH_CHK_HI  = 4'd11,
    PH_CHK_LO  = 4'd12,
    PH_TRAIL   = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_COLON   = 3'd0,
    ERR_DIGIT   = 3'd1,
    ERR_ENDED   = 3'd2,
    ERR_TYPE    = 3'd3,
    ERR_OVERLAP = 3'd4
  } err_e;

  localparam logic [7:0] RecData = 8'h00;
  localparam logic [7:0] RecEnd  = 8'h01;

  typedef struct packed {
    logic       end_of_input;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] fill_count;
    err_e        error_code;
  } result_t;

  // bit 4 set when the character is a hex digit, value in bits 3:0
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== design/ihex_in_reg.sv =====
// input register stage of the record parser
module ihex_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ihex_pkg::in_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output ihex_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  ihex_pkg::in_item_t item_q, item_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/ihex_decode.sv =====
// record state and per-character decode of the parser
module ihex_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ihex_pkg::in_item_t item_i,
  output logic               res_valid_o,
  output ihex_pkg::result_t  res_o
);

  ihex_pkg::phase_e phase_q, phase_d;
  logic             stopped_q, stopped_d;
  logic [3:0]       hold_q, hold_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       left_q, left_d;
  logic [16:0]      next_q, next_d;
  logic             known_q, known_d;

  logic [4:0]       nib;
  logic [7:0]       rec_type;
  logic [16:0]      eff_next;
  logic [15:0]      gap;

  assign nib      = ihex_pkg::nibble_of(item_i.char_in);
  assign rec_type = {hold_q, nib[3:0]};
  assign eff_next = known_q ? next_q : {1'b0, addr_q};
  assign gap      = addr_q - eff_next[15:0];

  always_comb begin
    phase_d     = phase_q;
    stopped_d   = stopped_q;
    hold_d      = hold_q;
    len_d       = len_q;
    addr_d      = addr_q;
    left_d      = left_q;
    next_d      = next_q;
    known_d     = known_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: ihex_pkg::KIND_DATA, data_byte: 8'd0, fill_count: 16'd0,
                    error_code: ihex_pkg::ERR_COLON};
    if (!stopped_q) begin
      if (phase_q == ihex_pkg::PH_TRAIL) begin
        phase_d = ihex_pkg::PH_COLON;
      end else if (item_i.end_of_input) begin
        stopped_d        = 1'b1;
        res_valid_o      = 1'b1;
        res_o.kind       = ihex_pkg::KIND_ERROR;
        res_o.error_code = ihex_pkg::ERR_ENDED;
      end else if (phase_q == ihex_pkg::PH_COLON || phase_q > ihex_pkg::PH_TRAIL) begin
        if (item_i.char_in == ihex_pkg::ColonChar) begin
          phase_d = ihex_pkg::PH_LEN_HI;
        end else begin
          stopped_d        = 1'b1;
          res_valid_o      = 1'b1;
          res_o.kind       = ihex_pkg::KIND_ERROR;
          res_o.error_code = ihex_pkg::ERR_COLON;
        end
      end else if (!nib[4]) begin
        stopped_d        = 1'b1;
        res_valid_o      = 1'b1;
        res_o.kind       = ihex_pkg::KIND_ERROR;
        res_o.error_code = ihex_pkg::ERR_DIGIT;
      end else begin
        unique case (phase_q)
          ihex_pkg::PH_LEN_HI: begin
            hold_d  = nib[3:0];
            phase_d = ihex_pkg::PH_LEN_LO;
          end
          ihex_pkg::PH_LEN_LO: begin
            len_d   = {hold_q, nib[3:0]};
            phase_d = ihex_pkg::PH_ADDR0;
          end
          ihex_pkg::PH_ADDR0: begin
            addr_d  = {12'd0, nib[3:0]};
            phase_d = ihex_pkg::PH_ADDR1;
          end
          ihex_pkg::PH_ADDR1: begin
            addr_d  = {addr_q[11:0], nib[3:0]};
            phase_d = ihex_pkg::PH_ADDR2;
          end
          ihex_pkg::PH_ADDR2: begin
            addr_d  = {addr_q[11:0], nib[3:0]};
            phase_d = ihex_pkg::PH_ADDR3;
          end
          ihex_pkg::PH_ADDR3: begin
            addr_d  = {addr_q[11:0], nib[3:0]};
            phase_d = ihex_pkg::PH_TYPE_HI;
          end
          ihex_pkg::PH_TYPE_HI: begin
            hold_d  = nib[3:0];
            phase_d = ihex_pkg::PH_TYPE_LO;
          end
          ihex_pkg::PH_TYPE_LO: begin
            if (rec_type == ihex_pkg::RecEnd) begin
              stopped_d   = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = ihex_pkg::KIND_DONE;
            end else if (rec_type != ihex_pkg::RecData) begin
              stopped_d        = 1'b1;
              res_valid_o      = 1'b1;
              res_o.kind       = ihex_pkg::KIND_ERROR;
              res_o.error_code = ihex_pkg::ERR_TYPE;
            end else begin
              known_d = 1'b1;
              next_d  = eff_next;
              if ({1'b0, addr_q} < eff_next) begin
                stopped_d        = 1'b1;
                res_valid_o      = 1'b1;
                res_o.kind       = ihex_pkg::KIND_ERROR;
                res_o.error_code = ihex_pkg::ERR_OVERLAP;
              end else begin
                next_d  = {1'b0, addr_q} + {9'd0, len_q};
                left_d  = len_q;
                phase_d = (len_q != 8'd0) ? ihex_pkg::PH_DATA_HI : ihex_pkg::PH_CHK_HI;
                if (gap != 16'd0) begin
                  res_valid_o      = 1'b1;
                  res_o.kind       = ihex_pkg::KIND_FILL;
                  res_o.fill_count = gap;
                end
              end
            end
          end
          ihex_pkg::PH_DATA_HI: begin
            hold_d  = nib[3:0];
            phase_d = ihex_pkg::PH_DATA_LO;
          end
          ihex_pkg::PH_DATA_LO: begin
            left_d          = left_q - 8'd1;
            phase_d         = (left_q != 8'd1) ? ihex_pkg::PH_DATA_HI : ihex_pkg::PH_CHK_HI;
            res_valid_o     = 1'b1;
            res_o.kind      = ihex_pkg::KIND_DATA;
            res_o.data_byte = {hold_q, nib[3:0]};
          end
          ihex_pkg::PH_CHK_HI: begin
            phase_d = ihex_pkg::PH_CHK_LO;
          end
          ihex_pkg::PH_CHK_LO: begin
            phase_d = ihex_pkg::PH_TRAIL;
          end
          default: begin
            phase_d = ihex_pkg::PH_COLON;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ihex_pkg::PH_COLON;
      stopped_q <= 1'b0;
      hold_q    <= 4'd0;
      len_q     <= 8'd0;
      addr_q    <= 16'd0;
      left_q    <= 8'd0;
      next_q    <= 17'd0;
      known_q   <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      stopped_q <= stopped_d;
      hold_q    <= hold_d;
      len_q     <= len_d;
      addr_q    <= addr_d;
      left_q    <= left_d;
      next_q    <= next_d;
      known_q   <= known_d;
    end
  end

`ifndef SYNTHESIS
  a_stop_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("parser left the stopped state");

  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o &&
     (res_o.kind == ihex_pkg::KIND_DONE || res_o.kind == ihex_pkg::KIND_ERROR))
    |=> stopped_q)
    else $error("done or error given without stopping");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == ihex_pkg::KIND_FILL) |-> (res_o.fill_count != 16'd0))
    else $error("zero-length fill run");

  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == ihex_pkg::KIND_DATA) |-> (phase_q == ihex_pkg::PH_DATA_LO))
    else $error("data byte outside a data digit pair");
`endif

endmodule

// ===== design/ihex_out_reg.sv =====
// result register of the record parser
module ihex_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  ihex_pkg::result_t res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ihex_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  ihex_pkg::result_t res_q, res_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/intel_hex_record_parser.sv =====
// top level of the intel hex record parser
// usage:
//   the slave side takes one text character per item: tdata holds the ascii
//   code, tlast marks that the stream ended (the character is then ignored)
//   the master side gives at most one result per character: tuser holds the
//   kind (data byte, zero-fill run, end record reached, error), tdata the byte,
//   the fill length and the error code, zero where the kind does not use them
//   the block keeps the next expected address, so a data record that starts
//   above it gives one fill result with the gap, one below it gives an overlap
//   error
//   after an end record or any error every further item is taken and dropped
//   until reset
// timing:
//   one item per cycle sustained while the master side does not stall; a result
//   is loaded into the result register when its item leaves the input register
//   (input register, then decode into the result register)
//   a stalled master side holds its result while one more item waits in the
//   input register; then tready drops until the result is taken
// reset:
//   rst_ni clears both stages and puts the parser in front of a record colon
module intel_hex_record_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ihex_pkg::TdataInW-1:0]   s_axis_tdata,   // [7:0] char_in
  input  logic                            s_axis_tlast,   // end_of_input
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ihex_pkg::TdataOutW-1:0]  m_axis_tdata,   // [7:0] data_byte,
                                                          // [23:8] fill_count,
                                                          // [26:24] error_code,
                                                          // [31:27] zero
  output logic [1:0]                      m_axis_tuser    // [1:0] kind
);

  ihex_pkg::in_item_t s_item;
  ihex_pkg::in_item_t cur_item;
  logic               cur_valid;
  logic               out_free;
  logic               advance;      // item leaves the input register this cycle
  logic               res_valid;
  ihex_pkg::result_t  res;
  ihex_pkg::result_t  out_res;

  assign s_item  = '{end_of_input: s_axis_tlast, char_in: s_axis_tdata};
  assign advance = cur_valid && out_free;

  // input register stage
  ihex_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (s_item),
    .take_i  (advance),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  // record phase tracking and result forming
  ihex_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (cur_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register towards the master side
  ihex_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (out_res)
  );

  // pack the result fields, lowest field first
  assign m_axis_tdata = {5'd0, out_res.error_code, out_res.fill_count, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

endmodule

// ===== sim/intel_hex_record_parser_tb.sv =====
// self-checking testbench of the intel hex record parser: directed and random records
module intel_hex_record_parser_tb;

  localparam int ItemTarget  = 1050;
  localparam int MaxIdle     = 7;
  localparam int DrainCycles = 8;

  // ways of ending the stream, the parser stops for good after any of them
  typedef enum int {
    TERM_END_RECORD,
    TERM_NO_COLON,
    TERM_BAD_DIGIT,
    TERM_CUT_SHORT,
    TERM_BAD_TYPE,
    TERM_OVERLAP
  } ending_e;

  typedef struct {
    logic [7:0]        ch;
    logic              last;
    bit                pinned;  // result typed in by hand rather than predicted
    ihex_pkg::result_t res;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] char_in
  logic        s_axis_tlast  = 1'b0;  // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // [7:0] data_byte, [23:8] fill_count, [26:24] error_code
  logic [1:0]  m_axis_tuser;  // [1:0] kind

  // parser state as the predictor sees it
  ihex_pkg::phase_e ps_phase  = ihex_pkg::PH_COLON;
  bit               ps_halted = 1'b0;
  logic [3:0]       ps_hold   = '0;
  logic [7:0]       ps_len    = '0;
  logic [15:0]      ps_addr   = '0;
  logic [7:0]       ps_type   = '0;
  logic [7:0]       ps_left   = '0;
  logic [16:0]      ps_next   = '0;
  bit               ps_known  = 1'b0;

  ihex_pkg::result_t pending_results[$];
  stim_row_t         directed_rows[$];
  int                mismatches = 0;
  int                items_sent = 0;
  bit                tx_burst   = 1'b0;
  bit                rx_burst   = 1'b0;

  intel_hex_record_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // digit value, or -1 for anything that is not a hex digit
  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    return -1;
  endfunction

  // hex digit in a random case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
  endfunction

  function automatic ihex_pkg::result_t stop_with(input ihex_pkg::err_e code);
    ihex_pkg::result_t r;
    r = '0;
    r.kind = ihex_pkg::KIND_ERROR;
    r.error_code = code;
    ps_halted = 1'b1;
    return r;
  endfunction

  // advances the parser state by one character, returns 1 when it gives a result
  function automatic bit parse_char(input logic [7:0] c, input logic eoi,
                                    output ihex_pkg::result_t r);
    int          v;
    logic [3:0]  nib;
    logic [16:0] gap;
    r = '0;
    if (ps_halted) return 1'b0;
    // the trailing character is taken whatever it is, end of input included
    if (ps_phase == ihex_pkg::PH_TRAIL) begin
      ps_phase = ihex_pkg::PH_COLON;
      return 1'b0;
    end
    if (eoi) begin
      r = stop_with(ihex_pkg::ERR_ENDED);
      return 1'b1;
    end
    if (ps_phase == ihex_pkg::PH_COLON) begin
      if (c != ihex_pkg::ColonChar) begin
        r = stop_with(ihex_pkg::ERR_COLON);
        return 1'b1;
      end
      ps_phase = ihex_pkg::PH_LEN_HI;
      return 1'b0;
    end
    v = hex_value(c);
    if (v < 0) begin
      r = stop_with(ihex_pkg::ERR_DIGIT);
      return 1'b1;
    end
    nib = v[3:0];
    case (ps_phase)
      ihex_pkg::PH_LEN_HI, ihex_pkg::PH_TYPE_HI, ihex_pkg::PH_DATA_HI: begin
        ps_hold = nib;
        ps_phase = ihex_pkg::phase_e'(ps_phase + 4'd1);
      end
      ihex_pkg::PH_LEN_LO: begin
        ps_len = {ps_hold, nib};
        ps_phase = ihex_pkg::PH_ADDR0;
      end
      ihex_pkg::PH_ADDR0: begin
        ps_addr = {12'd0, nib};
        ps_phase = ihex_pkg::PH_ADDR1;
      end
      ihex_pkg::PH_ADDR1, ihex_pkg::PH_ADDR2: begin
        ps_addr = {ps_addr[11:0], nib};
        ps_phase = ihex_pkg::phase_e'(ps_phase + 4'd1);
      end
      ihex_pkg::PH_ADDR3: begin
        ps_addr = {ps_addr[11:0], nib};
        ps_phase = ihex_pkg::PH_TYPE_HI;
      end
      ihex_pkg::PH_TYPE_LO: begin
        ps_type = {ps_hold, nib};
        if (ps_type == ihex_pkg::RecEnd) begin
          ps_halted = 1'b1;
          r.kind = ihex_pkg::KIND_DONE;
          return 1'b1;
        end
        if (ps_type != ihex_pkg::RecData) begin
          r = stop_with(ihex_pkg::ERR_TYPE);
          return 1'b1;
        end
        // the first data record sets the expected address itself
        if (!ps_known) begin
          ps_next = {1'b0, ps_addr};
          ps_known = 1'b1;
        end
        if ({1'b0, ps_addr} < ps_next) begin
          r = stop_with(ihex_pkg::ERR_OVERLAP);
          return 1'b1;
        end
        gap = {1'b0, ps_addr} - ps_next;
        ps_next = {1'b0, ps_addr} + {9'd0, ps_len};
        ps_left = ps_len;
        ps_phase = (ps_left != 8'd0) ? ihex_pkg::PH_DATA_HI : ihex_pkg::PH_CHK_HI;
        if (gap != 17'd0) begin
          r.kind = ihex_pkg::KIND_FILL;
          r.fill_count = gap[15:0];
          return 1'b1;
        end
      end
      ihex_pkg::PH_DATA_LO: begin
        ps_left = ps_left - 8'd1;
        ps_phase = (ps_left != 8'd0) ? ihex_pkg::PH_DATA_HI : ihex_pkg::PH_CHK_HI;
        r.kind = ihex_pkg::KIND_DATA;
        r.data_byte = {ps_hold, nib};
        return 1'b1;
      end
      ihex_pkg::PH_CHK_HI: ps_phase = ihex_pkg::PH_CHK_LO;
      ihex_pkg::PH_CHK_LO: ps_phase = ihex_pkg::PH_TRAIL;
      default:             ps_phase = ihex_pkg::PH_COLON;
    endcase
    return 1'b0;
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic eoi, input bit pinned,
                                  input ihex_pkg::result_t res);
    stim_row_t row;
    row.ch = c;
    row.last = eoi;
    row.pinned = pinned;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
  endfunction

  // one item over the slave side, with a random idle gap in front
  task automatic send_row(input stim_row_t row);
    int                idle;
    ihex_pkg::result_t r;
    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
    idle = tx_burst ? 0 : $urandom_range(0, MaxIdle);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row.ch;
    s_axis_tlast <= row.last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (parse_char(row.ch, row.last, r)) pending_results.push_back(row.pinned ? row.res : r);
  endtask

  task automatic send_char(input logic [7:0] c, input logic eoi);
    stim_row_t row;
    row.ch = c;
    row.last = eoi;
    row.pinned = 1'b0;
    row.res = '0;
    send_row(row);
  endtask

  task automatic send_hex(input logic [15:0] value, input int digits);
    for (int i = digits - 1; i >= 0; i--) send_char(hex_char(value[4*i +: 4]), 1'b0);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // well-formed data record, mostly contiguous, sometimes after a gap
  task automatic send_record();
    int len;
    int start;
    int gap_sel;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
    gap_sel = $urandom_range(0, 99);
    start = int'(ps_next);
    if (gap_sel >= 95) start += $urandom_range(1, 4096);
    else if (gap_sel >= 70) start += $urandom_range(1, 32);
    if (start + len > 32'h10000) start = int'(ps_next);
    send_char(ihex_pkg::ColonChar, 1'b0);
    send_hex(16'(len), 2);
    send_hex(start[15:0], 4);
    send_hex({8'd0, ihex_pkg::RecData}, 2);
    repeat (len) send_hex(16'($urandom_range(0, 255)), 2);
    send_hex(16'($urandom_range(0, 255)), 2);  // checksum, not checked
    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // closes the stream in one of the ways that stop the parser, then noise
  task automatic send_ending();
    ending_e    how;
    logic [7:0] c;
    int         lead;
    how = ending_e'($urandom_range(0, 5));
    lead = $urandom_range(0, 5);
    case (how)
      TERM_END_RECORD: begin
        send_char(ihex_pkg::ColonChar, 1'b0);
        send_hex(16'($urandom_range(0, 255)), 2);
        send_hex(16'($urandom_range(0, 65535)), 4);
        send_hex({8'd0, ihex_pkg::RecEnd}, 2);
      end
      TERM_NO_COLON: begin
        do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::ColonChar);
        send_char(c, 1'b0);
      end
      TERM_BAD_DIGIT: begin
        send_char(ihex_pkg::ColonChar, 1'b0);
        repeat (lead) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
        send_char(c, 1'b0);
      end
      TERM_CUT_SHORT: begin
        // a lead of zero cuts the stream where a colon is due
        if (lead > 0) send_char(ihex_pkg::ColonChar, 1'b0);
        repeat (lead) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      TERM_BAD_TYPE: begin
        send_char(ihex_pkg::ColonChar, 1'b0);
        send_hex(16'($urandom_range(0, 255)), 2);
        send_hex(ps_next[15:0], 4);
        send_hex(16'($urandom_range(2, 255)), 2);
      end
      default: begin
        send_char(ihex_pkg::ColonChar, 1'b0);
        send_hex(16'($urandom_range(0, 255)), 2);
        send_hex(16'($urandom_range(0, (ps_next > 17'hffff) ? 32'hffff : int'(ps_next) - 1)),
                 4);
        send_hex({8'd0, ihex_pkg::RecData}, 2);
      end
    endcase
    // everything after the stop is dropped
    repeat (8) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic check_result();
    ihex_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d, tdata %h", m_axis_tuser, m_axis_tdata);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (m_axis_tuser !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
        mismatches++;
      end
      if (m_axis_tdata[7:0] !== want.data_byte) begin
        $error("data_byte: expected %h, actual %h", want.data_byte, m_axis_tdata[7:0]);
        mismatches++;
      end
      if (m_axis_tdata[23:8] !== want.fill_count) begin
        $error("fill_count: expected %0d, actual %0d", want.fill_count, m_axis_tdata[23:8]);
        mismatches++;
      end
      if (m_axis_tdata[26:24] !== want.error_code) begin
        $error("error_code: expected %0d, actual %0d", want.error_code, m_axis_tdata[26:24]);
        mismatches++;
      end
    end
  endtask

  // master side: random stall in front of every result
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result();
    end
  end

  initial begin
    ihex_pkg::result_t typed;
    // first record: zero length, so it goes straight to the checksum and sets the
    // expected address without a fill; its trailing character carries tlast, which is ignored there
    add_text(":00000000FF");
    add_row(8'h80, 1'b1, 1'b0, '0);
    // second record one byte at 0003: a fill of three, then a byte in mixed case
    add_text(":0100030");
    typed = '0;
    typed.kind = ihex_pkg::KIND_FILL;
    typed.fill_count = 16'd3;
    add_row("0", 1'b0, 1'b1, typed);
    add_row("f", 1'b0, 1'b0, '0);
    typed = '0;
    typed.kind = ihex_pkg::KIND_DATA;
    typed.data_byte = 8'hff;
    add_row("F", 1'b0, 1'b1, typed);
    add_text("00");
    add_row(8'h0a, 1'b0, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    drain_results();

    while (items_sent < ItemTarget) begin
      send_record();
      if ($urandom_range(0, 11) == 0) drain_results();
    end
    send_ending();
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/ihex_pkg.sv
design/ihex_in_reg.sv
design/ihex_decode.sv
design/ihex_out_reg.sv
design/intel_hex_record_parser.sv
sim/intel_hex_record_parser_tb.sv
